// ----- rtl/mppc_pkg.sv -----
// ----------------------------------------------------------------------------
// mppc_pkg
// Shared widths, constants and codes for the motor position PI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mppc_pkg;

    // default encoder delta width
    localparam int DELTA_WIDTH_DEF = 16;

    // field widths
    localparam int POS_W   = 32;
    localparam int VEL_W   = 30;
    localparam int DUTY_W  = 17;
    localparam int TGT_W   = 9;
    localparam int GAIN_W  = 16;
    localparam int INTV_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;

    // shift-add multiplier: multiplier operand is consumed msb first
    localparam int MUL_B_W = 17;
    localparam int MUL_A_W = 43;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // restoring divider: 48-bit dividend, 16-bit divisor
    localparam int DIV_N   = 48;
    localparam int REM_W   = INTV_W + 1;

    // step counter covers the longest sweep
    localparam int CNT_W   = $clog2(DIV_N);

    // control path widths
    localparam int ERR_W   = DIV_N + 3;
    localparam int ACC_W   = MUL_P_W + 1;
    localparam int Q_SHIFT = 24;
    localparam int KI_SHIFT = 8;
    localparam int DQ_W    = ACC_W - Q_SHIFT;

    // scale factors: velocity is 10000*delta, angle is position*360*256
    localparam logic [MUL_B_W-1:0] VEL_SCALE   = MUL_B_W'(10000);
    localparam logic [MUL_B_W-1:0] ANGLE_SCALE = MUL_B_W'(92160);

    // velocity saturation bounds
    localparam logic [DIV_N-1:0] VEL_POS_LIM = DIV_N'((64'd1 << (VEL_W - 1)) - 64'd1);
    localparam logic [DIV_N-1:0] VEL_NEG_LIM = DIV_N'(64'd1 << (VEL_W - 1));
    localparam logic signed [VEL_W-1:0] VEL_MAX = VEL_W'((64'd1 << (VEL_W - 1)) - 64'd1);
    localparam logic signed [VEL_W-1:0] VEL_MIN = VEL_W'(64'd1 << (VEL_W - 1));

    // error clamp, 2^42 in Q.8 degrees
    localparam logic signed [ERR_W-1:0] ERR_CLAMP  = ERR_W'(64'sd4398046511104);
    localparam logic signed [ERR_W-1:0] ERR_NCLAMP = -ERR_CLAMP;

    // rounding offset for truncation toward zero
    localparam logic [ACC_W-1:0] Q_ROUND = ACC_W'((64'd1 << Q_SHIFT) - 64'd1);

    // command characters
    localparam logic [CHAR_W-1:0] CMD_NEG180 = 8'h31;
    localparam logic [CHAR_W-1:0] CMD_NEG90  = 8'h32;
    localparam logic [CHAR_W-1:0] CMD_ZERO   = 8'h33;
    localparam logic [CHAR_W-1:0] CMD_POS90  = 8'h34;
    localparam logic [CHAR_W-1:0] CMD_POS180 = 8'h35;

    // target angles in degrees
    localparam logic signed [TGT_W-1:0] TGT_NEG180 = -9'sd180;
    localparam logic signed [TGT_W-1:0] TGT_NEG90  = -9'sd90;
    localparam logic signed [TGT_W-1:0] TGT_ZERO   = 9'sd0;
    localparam logic signed [TGT_W-1:0] TGT_POS90  = 9'sd90;
    localparam logic signed [TGT_W-1:0] TGT_POS180 = 9'sd180;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP    = 2'd0,
        CFG_KI    = 2'd1,
        CFG_LIMIT = 2'd2,
        CFG_CPT   = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [GAIN_W-1:0] KP_RST    = 16'd4588;
    localparam logic [GAIN_W-1:0] KI_RST    = 16'd6554;
    localparam logic [GAIN_W-1:0] LIMIT_RST = 16'd200;
    localparam logic [GAIN_W-1:0] CPT_RST   = 16'd1216;

endpackage

`default_nettype wire

// ----- rtl/motor_position_pi_controller.sv -----
// ----------------------------------------------------------------------------
// motor_position_pi_controller
// PI position loop with encoder accumulation, velocity and angle estimation.
// ----------------------------------------------------------------------------
// A command word is taken whenever the block is idle and only changes the
// target angle. A tick word is not followed by another accepted word until
// its result has been written to the output register. With a zero interval
// the velocity division is skipped. The work goes into one shared shift-add
// multiplier that handles one multiplier bit per cycle (three 17-step
// products: 10000*delta, 92160*position and kp*error) and one restoring
// divider that produces one quotient bit per cycle (two 48-step quotients:
// velocity and angle), plus six steps for saturation, error, integrator and
// duty. A finished result waits in the output register while the next word
// is accepted; the duty step of that next tick then waits for as long as the
// held result is stalled.
`default_nettype none

module motor_position_pi_controller
    import mppc_pkg::*;
#(
    parameter int DELTA_WIDTH = DELTA_WIDTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // config write
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [GAIN_W-1:0]           i_cfg_data,
    // input words
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_mode,
    input  wire  [DELTA_WIDTH-1:0]      i_delta_raw,
    input  wire  [INTV_W-1:0]           i_delta_interval,
    input  wire  [CHAR_W-1:0]           i_command_char,
    // result words
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [GAIN_W-1:0]           o_duty_magnitude,
    output logic                        o_reverse_dir,
    output logic signed [POS_W-1:0]     o_position_count,
    output logic signed [VEL_W-1:0]     o_velocity,
    output logic                        o_velocity_invalid
);

    typedef enum logic [3:0] {
        S_IDLE, S_VMUL, S_VDIV, S_VSAT, S_AMUL, S_ADIV,
        S_ERR, S_KLD, S_KMUL, S_ACC1, S_ACC2, S_DUTY
    } t_state;

    // control state
    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;

    // config registers
    logic [GAIN_W-1:0]          r_kp_gain, n_kp_gain;
    logic [GAIN_W-1:0]          r_ki_gain, n_ki_gain;
    logic [GAIN_W-1:0]          r_duty_limit, n_duty_limit;
    logic [GAIN_W-1:0]          r_cpt, n_cpt;

    // loop state
    logic signed [POS_W-1:0]    r_position, n_position;
    logic signed [DUTY_W-1:0]   r_duty_reg, n_duty_reg;
    logic                       r_error_side, n_error_side;
    logic signed [TGT_W-1:0]    r_target_angle, n_target_angle;

    // datapath registers
    logic [MUL_A_W-1:0]         r_mul_a, n_mul_a;
    logic [MUL_B_W-1:0]         r_mul_b, n_mul_b;
    logic [MUL_P_W-1:0]         r_mul_p, n_mul_p;
    logic [INTV_W-1:0]          r_div_d, n_div_d;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic [DIV_N-1:0]           r_quo, n_quo;
    logic                       r_delta_neg, n_delta_neg;
    logic                       r_vel_inv, n_vel_inv;
    logic signed [VEL_W-1:0]    r_velocity, n_velocity;
    logic signed [ERR_W-1:0]    r_err, n_err;
    logic                       r_err_neg, n_err_neg;
    logic                       r_err_zero, n_err_zero;
    logic signed [ACC_W-1:0]    r_acc, n_acc;

    // output payload
    logic [GAIN_W-1:0]          r_out_mag, n_out_mag;
    logic                       r_out_rev, n_out_rev;
    logic signed [POS_W-1:0]    r_out_pos, n_out_pos;
    logic signed [VEL_W-1:0]    r_out_vel, n_out_vel;
    logic                       r_out_inv, n_out_inv;

    // delta sign extension and magnitude
    logic signed [DELTA_WIDTH-1:0]  w_delta_s;
    logic signed [POS_W-1:0]        w_delta_ext;
    logic [POS_W-1:0]               w_delta_mag;
    logic [POS_W-1:0]               w_pos_mag;

    assign w_delta_s   = i_delta_raw;
    assign w_delta_ext = POS_W'(w_delta_s);
    assign w_delta_mag = w_delta_ext[POS_W-1] ? $unsigned(-w_delta_ext)
                                              : $unsigned(w_delta_ext);
    assign w_pos_mag   = r_position[POS_W-1] ? $unsigned(-r_position)
                                             : $unsigned(r_position);

    // one shift-add step, multiplier bits msb first
    logic [MUL_P_W-1:0] w_mul_step;
    assign w_mul_step = {r_mul_p[MUL_P_W-2:0], 1'b0}
                      + (r_mul_b[MUL_B_W-1] ? MUL_P_W'(r_mul_a) : '0);

    // one restoring division step
    logic [REM_W-1:0]   w_div_t;
    logic               w_div_ge;
    logic [REM_W-1:0]   w_rem_next;
    logic [DIV_N-1:0]   w_quo_next;
    assign w_div_t    = {r_rem[REM_W-2:0], r_quo[DIV_N-1]};
    assign w_div_ge   = w_div_t >= REM_W'(r_div_d);
    assign w_rem_next = w_div_ge ? (w_div_t - REM_W'(r_div_d)) : w_div_t;
    assign w_quo_next = {r_quo[DIV_N-2:0], w_div_ge};

    // velocity from quotient magnitude
    logic [VEL_W-1:0]   w_vel_low;
    assign w_vel_low = r_quo[VEL_W-1:0];

    // angle error in Q.8 degrees
    logic signed [ERR_W-1:0] w_tgt_q8;
    logic signed [ERR_W-1:0] w_angle;
    assign w_tgt_q8 = ERR_W'($signed({r_target_angle, 8'b0}));
    assign w_angle  = $signed(ERR_W'(r_quo));

    // clamped error magnitude
    logic signed [ERR_W-1:0] w_err_abs;
    logic [MUL_A_W-1:0]      w_err_mag;
    assign w_err_abs = r_err[ERR_W-1] ? -r_err : r_err;
    assign w_err_mag = ((r_err > ERR_CLAMP) || (r_err < ERR_NCLAMP))
                     ? MUL_A_W'(ERR_CLAMP) : w_err_abs[MUL_A_W-1:0];

    // integrator terms, kept only while the error keeps its side
    logic                    w_same_side;
    logic signed [ACC_W-1:0] w_p_signed;
    logic signed [ACC_W-1:0] w_ki8;
    logic signed [ACC_W-1:0] w_ki_term;
    logic signed [ACC_W-1:0] w_duty_q24;
    assign w_same_side = (!r_err_neg) == r_error_side;
    assign w_p_signed  = r_err_neg ? -$signed(ACC_W'(r_mul_p)) : $signed(ACC_W'(r_mul_p));
    assign w_ki8       = $signed(ACC_W'(r_ki_gain) << KI_SHIFT);
    assign w_ki_term   = (w_same_side && !r_err_zero) ? (r_err_neg ? -w_ki8 : w_ki8) : '0;
    assign w_duty_q24  = w_same_side ? (ACC_W'(r_duty_reg) <<< Q_SHIFT) : '0;

    // duty: truncate toward zero, then saturate
    logic [ACC_W-1:0]        w_acc_rnd;
    logic signed [DQ_W-1:0]  w_duty_t;
    logic signed [DQ_W-1:0]  w_lim;
    logic signed [DQ_W-1:0]  w_duty_sat;
    logic signed [DQ_W-1:0]  w_duty_abs;
    assign w_acc_rnd  = r_acc[ACC_W-1] ? ($unsigned(r_acc) + Q_ROUND) : $unsigned(r_acc);
    assign w_duty_t   = w_acc_rnd[ACC_W-1:Q_SHIFT];
    assign w_lim      = $signed(DQ_W'(r_duty_limit));
    assign w_duty_sat = (w_duty_t > w_lim)  ? w_lim :
                        (w_duty_t < -w_lim) ? -w_lim : w_duty_t;
    assign w_duty_abs = w_duty_sat[DQ_W-1] ? -w_duty_sat : w_duty_sat;

    // next-state logic
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_out_valid    = r_out_valid;
        n_kp_gain      = r_kp_gain;
        n_ki_gain      = r_ki_gain;
        n_duty_limit   = r_duty_limit;
        n_cpt          = r_cpt;
        n_position     = r_position;
        n_duty_reg     = r_duty_reg;
        n_error_side   = r_error_side;
        n_target_angle = r_target_angle;
        n_mul_a        = r_mul_a;
        n_mul_b        = r_mul_b;
        n_mul_p        = r_mul_p;
        n_div_d        = r_div_d;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_delta_neg    = r_delta_neg;
        n_vel_inv      = r_vel_inv;
        n_velocity     = r_velocity;
        n_err          = r_err;
        n_err_neg      = r_err_neg;
        n_err_zero     = r_err_zero;
        n_acc          = r_acc;
        n_out_mag      = r_out_mag;
        n_out_rev      = r_out_rev;
        n_out_pos      = r_out_pos;
        n_out_vel      = r_out_vel;
        n_out_inv      = r_out_inv;

        // config writes
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:    n_kp_gain    = i_cfg_data;
                CFG_KI:    n_ki_gain    = i_cfg_data;
                CFG_LIMIT: n_duty_limit = i_cfg_data;
                CFG_CPT:   n_cpt        = i_cfg_data;
                default:   n_kp_gain    = r_kp_gain;
            endcase
        end

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode) begin
                        // setpoint command
                        case (i_command_char)
                            CMD_NEG180: n_target_angle = TGT_NEG180;
                            CMD_NEG90:  n_target_angle = TGT_NEG90;
                            CMD_ZERO:   n_target_angle = TGT_ZERO;
                            CMD_POS90:  n_target_angle = TGT_POS90;
                            CMD_POS180: n_target_angle = TGT_POS180;
                            default:    n_target_angle = r_target_angle;
                        endcase
                    end else begin
                        // control tick: accumulate and start 10000*|delta|
                        n_position  = r_position + w_delta_ext;
                        n_delta_neg = w_delta_ext[POS_W-1];
                        n_vel_inv   = (i_delta_interval == '0);
                        n_div_d     = i_delta_interval;
                        n_mul_a     = MUL_A_W'(w_delta_mag);
                        n_mul_b     = VEL_SCALE;
                        n_mul_p     = '0;
                        n_cnt       = CNT_W'(MUL_B_W - 1);
                        n_state     = S_VMUL;
                    end
                end
            end
            S_VMUL: begin
                n_mul_p = w_mul_step;
                n_mul_b = {r_mul_b[MUL_B_W-2:0], 1'b0};
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (r_vel_inv) begin
                        n_state = S_VSAT;
                    end else begin
                        n_quo   = w_mul_step[DIV_N-1:0];
                        n_rem   = '0;
                        n_cnt   = CNT_W'(DIV_N - 1);
                        n_state = S_VDIV;
                    end
                end
            end
            S_VDIV: begin
                n_rem = w_rem_next;
                n_quo = w_quo_next;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_VSAT;
                end
            end
            S_VSAT: begin
                // signed, saturated velocity
                if (r_vel_inv) begin
                    n_velocity = '0;
                end else if (r_delta_neg) begin
                    n_velocity = (r_quo > VEL_NEG_LIM) ? VEL_MIN : -$signed(w_vel_low);
                end else begin
                    n_velocity = (r_quo > VEL_POS_LIM) ? VEL_MAX : $signed(w_vel_low);
                end
                // start 92160*|position|
                n_mul_a = MUL_A_W'(w_pos_mag);
                n_mul_b = ANGLE_SCALE;
                n_mul_p = '0;
                n_cnt   = CNT_W'(MUL_B_W - 1);
                n_state = S_AMUL;
            end
            S_AMUL: begin
                n_mul_p = w_mul_step;
                n_mul_b = {r_mul_b[MUL_B_W-2:0], 1'b0};
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_quo   = w_mul_step[DIV_N-1:0];
                    n_rem   = '0;
                    n_div_d = (r_cpt == '0) ? INTV_W'(1) : r_cpt;
                    n_cnt   = CNT_W'(DIV_N - 1);
                    n_state = S_ADIV;
                end
            end
            S_ADIV: begin
                n_rem = w_rem_next;
                n_quo = w_quo_next;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                // target minus signed angle
                n_err   = r_position[POS_W-1] ? (w_tgt_q8 + w_angle) : (w_tgt_q8 - w_angle);
                n_state = S_KLD;
            end
            S_KLD: begin
                // start kp*|error|
                n_err_neg  = r_err[ERR_W-1];
                n_err_zero = (r_err == '0);
                n_mul_a    = w_err_mag;
                n_mul_b    = MUL_B_W'(r_kp_gain);
                n_mul_p    = '0;
                n_cnt      = CNT_W'(MUL_B_W - 1);
                n_state    = S_KMUL;
            end
            S_KMUL: begin
                n_mul_p = w_mul_step;
                n_mul_b = {r_mul_b[MUL_B_W-2:0], 1'b0};
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_ACC1;
                end
            end
            S_ACC1: begin
                n_acc   = w_p_signed + w_ki_term;
                n_state = S_ACC2;
            end
            S_ACC2: begin
                n_acc   = r_acc + w_duty_q24;
                n_state = S_DUTY;
            end
            S_DUTY: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_duty_reg   = DUTY_W'(w_duty_sat);
                    n_error_side = !r_err_neg;
                    n_out_mag    = w_duty_abs[GAIN_W-1:0];
                    n_out_rev    = w_duty_sat[DQ_W-1] || (w_duty_sat == '0);
                    n_out_pos    = r_position;
                    n_out_vel    = r_velocity;
                    n_out_inv    = r_vel_inv;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_kp_gain      <= KP_RST;
            r_ki_gain      <= KI_RST;
            r_duty_limit   <= LIMIT_RST;
            r_cpt          <= CPT_RST;
            r_position     <= '0;
            r_duty_reg     <= '0;
            r_error_side   <= 1'b0;
            r_target_angle <= TGT_ZERO;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_out_valid    <= n_out_valid;
            r_kp_gain      <= n_kp_gain;
            r_ki_gain      <= n_ki_gain;
            r_duty_limit   <= n_duty_limit;
            r_cpt          <= n_cpt;
            r_position     <= n_position;
            r_duty_reg     <= n_duty_reg;
            r_error_side   <= n_error_side;
            r_target_angle <= n_target_angle;
        end
        r_mul_a     <= n_mul_a;
        r_mul_b     <= n_mul_b;
        r_mul_p     <= n_mul_p;
        r_div_d     <= n_div_d;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_delta_neg <= n_delta_neg;
        r_vel_inv   <= n_vel_inv;
        r_velocity  <= n_velocity;
        r_err       <= n_err;
        r_err_neg   <= n_err_neg;
        r_err_zero  <= n_err_zero;
        r_acc       <= n_acc;
        r_out_mag   <= n_out_mag;
        r_out_rev   <= n_out_rev;
        r_out_pos   <= n_out_pos;
        r_out_vel   <= n_out_vel;
        r_out_inv   <= n_out_inv;
    end

    // ports
    assign o_cfg_ready        = 1'b1;
    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_duty_magnitude   = r_out_mag;
    assign o_reverse_dir      = r_out_rev;
    assign o_position_count   = r_out_pos;
    assign o_velocity         = r_out_vel;
    assign o_velocity_invalid = r_out_inv;

    // a new result only comes from the duty step
    a_result_from_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DUTY))
        else $error("result raised outside the duty step");

    // remainder stays below the divisor during division
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_VDIV) || (r_state == S_ADIV)) |-> (r_rem < REM_W'(r_div_d)))
        else $error("divider remainder reached the divisor");

    // forward drive needs a nonzero magnitude
    a_dir_vs_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_rev) |-> (r_out_mag != '0))
        else $error("forward direction with zero duty");

    // invalid velocity is reported as zero
    a_invalid_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inv) |-> (r_out_vel == '0))
        else $error("invalid velocity is not zero");

endmodule

`default_nettype wire
